>>> sv/led_fade_ramp_dither_scaler_defines.svh
// Assertion macros shared by the fade and dither scaler.
`ifndef LED_FADE_RAMP_DITHER_SCALER_DEFINES_SVH
`define LED_FADE_RAMP_DITHER_SCALER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/lfrd_pkg.sv
// Types and constants of the fade and dither scaler.
package lfrd_pkg;

    localparam int FADE_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FADE_W-1:0] FULL_LEVEL = 9'd256;

    localparam logic [CFG_DATA_W-1:0] FADE_IN_RESET  = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] FADE_OUT_RESET = 16'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT = 2'd1;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_CHANNEL = 1'b1;

    typedef logic [1:0] t_rail_ev;
    localparam t_rail_ev EV_NONE    = 2'd0;
    localparam t_rail_ev EV_BLANK   = 2'd1;
    localparam t_rail_ev EV_UNBLANK = 2'd2;

    typedef struct packed {
        logic        command;
        logic        want_on;
        logic [31:0] now_ms;
        logic [7:0]  channel_index;
        logic [7:0]  channel_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        scaled_value;
        logic [FADE_W-1:0] fade_level;
        logic              is_blanked;
        logic              is_fading;
        t_rail_ev          rail_event;
        logic              repaint;
    } t_out_item;

endpackage

>>> sv/lfrd_ramp_div.sv
// Bit-serial divider giving the 8-bit ramp progress (dividend * 256) / divisor.
module lfrd_ramp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [7:0]  o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_div;
    logic [7:0]  r_quo;

    logic [16:0] w_shift;
    logic        w_ge;

    // The dividend is below the divisor, so each step shifts in one zero bit.
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd7;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= i_divisor;
            r_quo <= 8'd0;
        end else if (r_busy) begin
            r_rem <= w_ge ? 16'(w_shift - {1'b0, r_div}) : w_shift[15:0];
            r_quo <= {r_quo[6:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> sv/lfrd_residue_ram.sv
// Dither residue memory with a registered read port and a clearing pass after reset.
module lfrd_residue_ram #(
    parameter int DEPTH = 198,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    output logic          o_clearing
);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr_active;

endmodule

>>> sv/led_fade_ramp_dither_scaler.sv
// Top level of the LED fade ramp and temporal dither scaler.
// Channel items pass from the input transfer through S_CHAN to S_FIN; tick items pass
// through S_TICK0 and S_TICK1, then straight to S_FIN, or through S_MUL and S_APPLY,
// with the eight-step serial divider in S_DIV first when the ramp progress needs it.
// One item is in flight at a time; the next input transfer is taken the cycle after the
// previous result is loaded into the output register. Reset is synchronous and active low;
// afterwards a clearing pass zeroes the residue memory while no item is taken.
module led_fade_ramp_dither_scaler #(
    parameter int NUM_CHANNELS = 198
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lfrd_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lfrd_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lfrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lfrd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    `include "led_fade_ramp_dither_scaler_defines.svh"

    localparam int AW = $clog2(NUM_CHANNELS);
    localparam int FW = lfrd_pkg::FADE_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TICK0 = 3'd1;
    localparam logic [2:0] S_TICK1 = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_APPLY = 3'd5;
    localparam logic [2:0] S_CHAN  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]              r_state;
    lfrd_pkg::t_in_item      r_item;

    // Configuration registers.
    logic [15:0]             r_fade_in_ms;
    logic [15:0]             r_fade_out_ms;

    // Ramp state.
    logic [FW-1:0]           r_fade;
    logic [FW-1:0]           r_target;
    logic [FW-1:0]           r_start_level;
    logic [31:0]             r_start_time;
    logic                    r_blanked;

    // Per-item working registers.
    lfrd_pkg::t_rail_ev      r_ev;
    logic                    r_repaint;
    logic [7:0]              r_scaled;
    logic [FW-1:0]           r_prog;
    logic [FW-1:0]           r_step;

    // Output register.
    logic                    r_out_valid;
    lfrd_pkg::t_out_item     r_out_item;

    logic                    w_accept;
    logic                    w_clearing;
    logic                    w_out_load;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [7:0]              w_div_quo;
    logic [15:0]             w_dur;
    logic [31:0]             w_elapsed;
    logic                    w_ramp_done;
    logic                    w_up;
    logic [FW-1:0]           w_span;
    logic [17:0]             w_span_prod;
    logic [FW-1:0]           w_fade_new;
    logic [AW+7:0]           w_rd_idx_ext;
    logic [AW+7:0]           w_ch_idx_ext;
    logic                    w_in_range;
    logic [7:0]              w_rd_data;
    logic                    w_res_we;
    logic [16:0]             w_prod;
    logic [8:0]              w_acc;
    logic [9:0]              w_whole;
    logic [7:0]              w_chan_res;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE) && !w_clearing;
    assign o_cfg_ready = 1'b1;
    assign w_out_load  = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    // Configuration writes; an index past the register list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_in_ms  <= lfrd_pkg::FADE_IN_RESET;
            r_fade_out_ms <= lfrd_pkg::FADE_OUT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lfrd_pkg::CFG_FADE_IN:  r_fade_in_ms  <= i_cfg_data;
                lfrd_pkg::CFG_FADE_OUT: r_fade_out_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ramp arithmetic, all on the already updated ramp registers.
    assign w_dur       = (r_target > r_start_level) ? r_fade_in_ms : r_fade_out_ms;
    assign w_elapsed   = r_item.now_ms - r_start_time;
    assign w_ramp_done = (w_elapsed >= {16'd0, w_dur});
    assign w_up        = (r_target >= r_start_level);
    assign w_span      = w_up ? (r_target - r_start_level) : (r_start_level - r_target);
    assign w_span_prod = {9'd0, w_span} * {9'd0, r_prog};
    assign w_fade_new  = w_up ? (r_start_level + r_step) : (r_start_level - r_step);
    assign w_div_start = (r_state == S_TICK1) && (r_fade != r_target) && !w_ramp_done;

    lfrd_ramp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_elapsed[15:0]),
        .i_divisor  (w_dur),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // Channel scaling. The residue is read at the input transfer and used in the next cycle, in S_CHAN.
    assign w_rd_idx_ext = {{AW{1'b0}}, i_in_item.channel_index};
    assign w_ch_idx_ext = {{AW{1'b0}}, r_item.channel_index};
    assign w_in_range   = (w_ch_idx_ext < (AW+8)'(NUM_CHANNELS));
    assign w_prod       = {9'd0, r_item.channel_value} * {8'd0, r_fade};
    assign w_acc        = {1'b0, w_rd_data} + {1'b0, w_prod[7:0]};
    assign w_whole      = {1'b0, w_prod[16:8]} + (w_in_range ? {9'd0, w_acc[8]} : 10'd0);
    assign w_chan_res   = (w_whole > 10'd255) ? 8'hFF : w_whole[7:0];
    assign w_res_we     = (r_state == S_CHAN) && !r_blanked && !r_fade[8] && w_in_range;

    lfrd_residue_ram #(
        .DEPTH (NUM_CHANNELS),
        .AW    (AW)
    ) u_residue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept),
        .i_rd_addr  (w_rd_idx_ext[AW-1:0]),
        .o_rd_data  (w_rd_data),
        .i_wr_en    (w_res_we),
        .i_wr_addr  (w_ch_idx_ext[AW-1:0]),
        .i_wr_data  (w_acc[7:0]),
        .o_clearing (w_clearing)
    );

    // Sequencer and ramp state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fade        <= lfrd_pkg::FULL_LEVEL;
            r_target      <= lfrd_pkg::FULL_LEVEL;
            r_start_level <= lfrd_pkg::FULL_LEVEL;
            r_start_time  <= 32'd0;
            r_blanked     <= 1'b0;
            r_ev          <= lfrd_pkg::EV_NONE;
            r_repaint     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ev      <= lfrd_pkg::EV_NONE;
                        r_repaint <= 1'b0;
                        r_state   <= (i_in_item.command == lfrd_pkg::CMD_CHANNEL) ?
                                     S_CHAN : S_TICK0;
                    end
                end
                S_TICK0: begin
                    // Light wanted while the rail is down restarts the ramp from black.
                    if (r_item.want_on && r_blanked) begin
                        r_blanked     <= 1'b0;
                        r_ev          <= lfrd_pkg::EV_UNBLANK;
                        r_fade        <= '0;
                        r_target      <= lfrd_pkg::FULL_LEVEL;
                        r_start_level <= '0;
                        r_start_time  <= r_item.now_ms;
                    end else if ((r_item.want_on ? lfrd_pkg::FULL_LEVEL : FW'(0))
                                 != r_target) begin
                        r_target      <= r_item.want_on ? lfrd_pkg::FULL_LEVEL : FW'(0);
                        r_start_level <= r_fade;
                        r_start_time  <= r_item.now_ms;
                    end
                    r_state <= S_TICK1;
                end
                S_TICK1: begin
                    if (r_fade == r_target) begin
                        if ((r_target == '0) && !r_blanked) begin
                            r_blanked <= 1'b1;
                            r_ev      <= lfrd_pkg::EV_BLANK;
                        end
                        r_state <= S_FIN;
                    end else if (w_ramp_done) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_fade    <= w_fade_new;
                    r_repaint <= 1'b1;
                    if ((w_fade_new == '0) && (r_target == '0) && !r_blanked) begin
                        r_blanked <= 1'b1;
                        r_ev      <= lfrd_pkg::EV_BLANK;
                    end
                    r_state <= S_FIN;
                end
                S_CHAN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers of the current item.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item   <= i_in_item;
            r_scaled <= 8'd0;
        end
        if ((r_state == S_TICK1) && w_ramp_done) begin
            r_prog <= lfrd_pkg::FULL_LEVEL;
        end else if ((r_state == S_DIV) && w_div_done) begin
            r_prog <= {1'b0, w_div_quo};
        end
        if (r_state == S_MUL) begin
            r_step <= w_span_prod[16:8];
        end
        if (r_state == S_CHAN) begin
            if (r_blanked) begin
                r_scaled <= 8'd0;
            end else if (r_fade[8]) begin
                r_scaled <= r_item.channel_value;
            end else begin
                r_scaled <= w_chan_res;
            end
        end
    end

    // Output register: a waiting result does not hold back the next input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_item.scaled_value <= r_scaled;
            r_out_item.fade_level   <= r_fade;
            r_out_item.is_blanked   <= r_blanked;
            r_out_item.is_fading    <= (r_fade != r_target);
            r_out_item.rail_event   <= r_ev;
            r_out_item.repaint      <= r_repaint;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The brightness scalar never leaves its range.
    `LFRD_ASSERT_IMPLY(a_fade_range, i_clk, i_rst_n, 1'b1, r_fade <= lfrd_pkg::FULL_LEVEL)
    // A result delivered while the rail is down carries no light.
    `LFRD_ASSERT_IMPLY(a_blank_dark, i_clk, i_rst_n, o_out_valid && o_out_item.is_blanked,
        o_out_item.scaled_value == 8'd0)
    // A rail event agrees with the reported rail state.
    `LFRD_ASSERT_IMPLY(a_event_rail, i_clk, i_rst_n,
        o_out_valid && (o_out_item.rail_event != lfrd_pkg::EV_NONE),
        o_out_item.is_blanked == (o_out_item.rail_event == lfrd_pkg::EV_BLANK))
    // Only one item is in flight: an input transfer closes the input side.
    `LFRD_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LED fade ramp and temporal dither scaler.
module tb_top;

    localparam int NUM_CH        = 198;
    localparam int RANDOM_ITEMS  = 450;
    localparam int PHASES        = 6;
    localparam int LONG_HOLD     = 80;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 50;

    // The register map only names two registers; the other two indexes must be ignored.
    localparam logic [lfrd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [lfrd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // The scoreboard keeps its own copy of the ramp, the rail state, the dither residues
    // and the two duration registers. Every accepted input item is run through it at once,
    // and the result it predicts waits in a queue until the block delivers its own.
    class fade_scoreboard;
        logic [15:0]         fade_in_ms;
        logic [15:0]         fade_out_ms;
        logic [8:0]          level;
        logic [8:0]          target;
        logic [8:0]          start_level;
        logic [31:0]         start_ms;
        logic                rail_down;
        logic [7:0]          residue [NUM_CH];
        lfrd_pkg::t_out_item results_due [$];
        int                  mismatches;

        function new();
            fade_in_ms  = lfrd_pkg::FADE_IN_RESET;
            fade_out_ms = lfrd_pkg::FADE_OUT_RESET;
            level       = lfrd_pkg::FULL_LEVEL;
            target      = lfrd_pkg::FULL_LEVEL;
            start_level = lfrd_pkg::FULL_LEVEL;
            start_ms    = 32'd0;
            rail_down   = 1'b0;
            foreach (residue[i]) residue[i] = 8'd0;
            mismatches  = 0;
        endfunction

        function void load_register(logic [lfrd_pkg::CFG_IDX_W-1:0] idx,
                                    logic [lfrd_pkg::CFG_DATA_W-1:0] data);
            if (idx == lfrd_pkg::CFG_FADE_IN) begin
                fade_in_ms = data;
            end else if (idx == lfrd_pkg::CFG_FADE_OUT) begin
                fade_out_ms = data;
            end
        endfunction

        function lfrd_pkg::t_out_item result_of(logic [7:0] scaled, lfrd_pkg::t_rail_ev ev,
                                                logic stepped);
            lfrd_pkg::t_out_item r;
            r.scaled_value = scaled;
            r.fade_level   = level;
            r.is_blanked   = rail_down;
            r.is_fading    = (level != target);
            r.rail_event   = ev;
            r.repaint      = stepped;
            return r;
        endfunction

        // One tick: retarget the ramp if needed, then place the level on the line from
        // the ramp start toward the target according to the elapsed time.
        function lfrd_pkg::t_out_item advance_ramp(logic want, logic [31:0] now);
            logic [8:0]         goal;
            lfrd_pkg::t_rail_ev ev;
            logic [31:0]        dur;
            logic [31:0]        elapsed;
            logic [31:0]        progress;
            logic [31:0]        span;
            goal = want ? lfrd_pkg::FULL_LEVEL : 9'd0;
            ev   = lfrd_pkg::EV_NONE;
            if (want && rail_down) begin
                // Light wanted while the rail is down: raise it and climb from black.
                rail_down   = 1'b0;
                ev          = lfrd_pkg::EV_UNBLANK;
                level       = 9'd0;
                target      = lfrd_pkg::FULL_LEVEL;
                start_level = 9'd0;
                start_ms    = now;
            end else if (goal != target) begin
                target      = goal;
                start_level = level;
                start_ms    = now;
            end
            if (level == target) begin
                if (target == 9'd0 && !rail_down) begin
                    rail_down = 1'b1;
                    ev        = lfrd_pkg::EV_BLANK;
                end
                return result_of(8'd0, ev, 1'b0);
            end
            dur     = (target > start_level) ? 32'(fade_in_ms) : 32'(fade_out_ms);
            elapsed = now - start_ms;
            // A zero duration always lands here, so it never reaches the divide.
            if (elapsed >= dur) begin
                progress = 32'd256;
            end else begin
                progress = (elapsed * 32'd256) / dur;
            end
            if (target >= start_level) begin
                span  = 32'(target) - 32'(start_level);
                level = 9'(32'(start_level) + span * progress / 32'd256);
            end else begin
                span  = 32'(start_level) - 32'(target);
                level = 9'(32'(start_level) - span * progress / 32'd256);
            end
            if (level == 9'd0 && target == 9'd0 && !rail_down) begin
                rail_down = 1'b1;
                ev        = lfrd_pkg::EV_BLANK;
            end
            return result_of(8'd0, ev, 1'b1);
        endfunction

        // One channel code scaled by the level, with the low product byte carried over
        // in that channel's residue.
        function lfrd_pkg::t_out_item scale_code(logic [7:0] idx, logic [7:0] code);
            logic [15:0] product;
            logic [8:0]  whole;
            logic [8:0]  carry_sum;
            logic [7:0]  scaled;
            if (rail_down) begin
                scaled = 8'd0;
            end else if (level >= lfrd_pkg::FULL_LEVEL) begin
                scaled = code;
            end else begin
                product = 16'(code) * 16'(level);
                whole   = {1'b0, product[15:8]};
                if (32'(idx) < NUM_CH) begin
                    carry_sum    = {1'b0, residue[idx]} + {1'b0, product[7:0]};
                    whole        = whole + {8'd0, carry_sum[8]};
                    residue[idx] = carry_sum[7:0];
                end
                scaled = (whole > 9'd255) ? 8'd255 : whole[7:0];
            end
            return result_of(scaled, lfrd_pkg::EV_NONE, 1'b0);
        endfunction

        function void note_item(lfrd_pkg::t_in_item item);
            if (item.command == lfrd_pkg::CMD_TICK) begin
                results_due.push_back(advance_ramp(item.want_on, item.now_ms));
            end else begin
                results_due.push_back(scale_code(item.channel_index, item.channel_value));
            end
        endfunction

        function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (act_val !== exp_val) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
                end
            end
        endfunction

        function void check_result(lfrd_pkg::t_out_item got);
            lfrd_pkg::t_out_item due;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result expected none, actual fade_level %0d scaled %0d",
                             $time, got.fade_level, got.scaled_value);
                end
                return;
            end
            due = results_due.pop_front();
            compare_field("scaled_value", 32'(due.scaled_value), 32'(got.scaled_value));
            compare_field("fade_level", 32'(due.fade_level), 32'(got.fade_level));
            compare_field("is_blanked", 32'(due.is_blanked), 32'(got.is_blanked));
            compare_field("is_fading", 32'(due.is_fading), 32'(got.is_fading));
            compare_field("rail_event", 32'(due.rail_event), 32'(got.rail_event));
            compare_field("repaint", 32'(due.repaint), 32'(got.repaint));
        endfunction
    endclass

    // Every input of the block holds a known value from time zero.
    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    lfrd_pkg::t_in_item              in_item   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    lfrd_pkg::t_out_item             out_item;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lfrd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lfrd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    fade_scoreboard sb;

    // Idle rates in percent per cycle. The stall rate and the hold request are read by the
    // receiver process, so the main process updates them with nonblocking assignments.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    led_fade_ramp_dither_scaler #(
        .NUM_CHANNELS(NUM_CH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls at the current rate, or a long hold-off when the main
    // process has asked for one. During the hold the block fills up and must stall
    // its input while the sender keeps offering.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            out_ready    <= 1'b0;
            hold_left    <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Output transfers are checked at the edge where they happen; all stimulus changes
    // land in the nonblocking region, so the sampled values are the settled ones.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_result(out_item);
        end
    end

    function automatic lfrd_pkg::t_in_item tick_item(logic want, logic [31:0] now);
        lfrd_pkg::t_in_item item;
        item.command       = lfrd_pkg::CMD_TICK;
        item.want_on       = want;
        item.now_ms        = now;
        item.channel_index = 8'($urandom);
        item.channel_value = 8'($urandom);
        return item;
    endfunction

    function automatic lfrd_pkg::t_in_item channel_item(logic [7:0] idx, logic [7:0] code);
        lfrd_pkg::t_in_item item;
        item.command       = lfrd_pkg::CMD_CHANNEL;
        item.want_on       = 1'($urandom);
        item.now_ms        = $urandom;
        item.channel_index = idx;
        item.channel_value = code;
        return item;
    endfunction

    // Offers one item after a random idle gap and returns at the edge of its transfer.
    // Valid is left high so that back-to-back items never see it dropped and raised in
    // the same time step; the next call or the drain decides its level.
    task automatic send_item(input lfrd_pkg::t_in_item item);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        sb.note_item(item);
    endtask

    // Register write; the caller lowers valid after the last write of a batch.
    task automatic write_config(input logic [lfrd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lfrd_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.load_register(idx, data);
    endtask

    // Stops offering and waits until every predicted result has been delivered.
    // Each item produces exactly one result, so an empty queue means the block is idle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.results_due.size() != 0) @(posedge clk);
    endtask

    initial begin
        logic [15:0] in_ms;
        logic [15:0] out_ms;
        logic [31:0] clock_ms;
        logic [31:0] step_max;
        logic [7:0]  idx;
        logic        heading;
        int          pick;

        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset durations (2000 ms up, 10000 ms down).
        // Full fade passes codes through untouched.
        send_item(channel_item(8'd0, 8'd255));
        send_item(channel_item(8'd197, 8'd0));
        // Already at full: no step, no event.
        send_item(tick_item(1'b1, 32'd100));
        // Start a fade-out, then land halfway down it.
        send_item(tick_item(1'b0, 32'd1000));
        send_item(tick_item(1'b0, 32'd6000));
        // Half fade: the residue of channel 5 fills up and carries on the second code.
        send_item(channel_item(8'd5, 8'd255));
        send_item(channel_item(8'd5, 8'd255));
        // Indexes past the last channel are truncated with no residue.
        send_item(channel_item(8'd250, 8'd200));
        send_item(channel_item(8'd198, 8'd255));
        // Direction change mid-ramp restarts from the current level.
        send_item(tick_item(1'b1, 32'd7000));
        send_item(tick_item(1'b1, 32'd8000));
        send_item(tick_item(1'b0, 32'd8500));
        // Ramp overrun reaches black and drops the rail.
        send_item(tick_item(1'b0, 32'd20000));
        // Channels are scaled to zero while the rail is down.
        send_item(channel_item(8'd3, 8'd255));
        send_item(tick_item(1'b0, 32'd20100));
        // Light wanted again: rail comes up and the ramp starts from black.
        send_item(tick_item(1'b1, 32'd20200));
        send_item(tick_item(1'b1, 32'd21000));
        send_item(channel_item(8'd197, 8'd128));
        send_item(channel_item(8'd0, 8'd1));
        // Timer wrap: a fade-out started just before the counter rolls over.
        send_item(tick_item(1'b1, 32'hFFFF_FFF0));
        send_item(tick_item(1'b0, 32'hFFFF_FC00));
        send_item(tick_item(1'b0, 32'h0000_0400));
        send_item(channel_item(8'd255, 8'd170));

        clock_ms = 32'd5000;
        heading  = 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin in_ms = 16'd0;     out_ms = 16'd0;     end
                1: begin in_ms = 16'hFFFF;  out_ms = 16'hFFFF;  end
                2: begin in_ms = 16'd1;     out_ms = 16'd1;     end
                3: begin in_ms = 16'd37;    out_ms = 16'd250;   end
                4: begin in_ms = 16'($urandom); out_ms = 16'($urandom); end
                default: begin in_ms = 16'd0; out_ms = 16'd3000; end
            endcase
            write_config(lfrd_pkg::CFG_FADE_IN, in_ms);
            write_config(lfrd_pkg::CFG_FADE_OUT, out_ms);
            if (p == 2) begin
                // Writes to the unused indexes must leave both durations alone.
                write_config(CFG_SPARE_A, 16'($urandom));
                write_config(CFG_SPARE_B, 16'($urandom));
            end
            cfg_valid <= 1'b0;

            // Busy sender with a slow receiver, then the reverse, then full speed.
            if (p < 2) begin
                send_idle_pct  = 6;
                recv_stall_pct <= 64;
            end else if (p < 4) begin
                send_idle_pct  = 64;
                recv_stall_pct <= 6;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct <= 0;
            end
            if (p == 1 || p == 4) begin
                holds_asked <= holds_asked + 1;
            end
            if (p == 4) begin
                // Run this phase across the wrap of the millisecond counter.
                clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 100000));
            end

            // Time steps scale with the longer ramp so most ramps finish in a handful of
            // ticks, and direction changes fall both mid-ramp and after settling.
            step_max = ((in_ms > out_ms) ? 32'(in_ms) : 32'(out_ms)) / 32'd3 + 32'd4;

            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    if ($urandom_range(0, 9) == 0) begin
                        idx = 8'($urandom_range(NUM_CH, 255));
                    end else begin
                        idx = 8'($urandom_range(0, NUM_CH - 1));
                    end
                    send_item(channel_item(idx, 8'($urandom)));
                end else if (pick < 93) begin
                    if ($urandom_range(0, 99) < 12) begin
                        heading = !heading;
                    end
                    clock_ms = clock_ms + 32'($urandom_range(0, step_max));
                    send_item(tick_item(heading, clock_ms));
                end else begin
                    // Noise: the clock jumps anywhere, backward included.
                    clock_ms = $urandom;
                    send_item(tick_item(1'($urandom), clock_ms));
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run including the clearing pass.
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
